// ===== hw/rtl/dsps_pkg.sv =====
`timescale 1ns / 1ps

package dsps_pkg;

  localparam int unsigned CMD_W  = 3;
  localparam int unsigned POS_W  = 8;
  localparam int unsigned PAN_W  = 5;
  localparam int unsigned TILT_W = 4;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned STEP_W = 5;

  localparam logic [STEP_W-1:0] STEP_RESET       = 5'd2;
  localparam logic [PAN_W-1:0]  PAN_POS_RESET    = 5'd15;
  localparam logic [TILT_W-1:0] TILT_POS_RESET   = 4'd5;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK     = 3'd0,
    CMD_PAN_UP   = 3'd1,
    CMD_PAN_DN   = 3'd2,
    CMD_TILT_UP  = 3'd3,
    CMD_TILT_DN  = 3'd4,
    CMD_SET_PAN  = 3'd5,
    CMD_SET_TILT = 3'd6
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

endpackage

// ===== hw/rtl/dsps_if.sv =====
`timescale 1ns / 1ps

interface dsps_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [dsps_pkg::CMD_W-1:0]  cmd;
  logic [dsps_pkg::POS_W-1:0]  position;

  modport source (output valid, cmd, position, input ready);
  modport sink   (input valid, cmd, position, output ready);
endinterface

interface dsps_res_if;
  logic                        valid;
  logic                        ready;
  logic                        pwm_pan;
  logic                        pwm_tilt;
  logic [dsps_pkg::PAN_W-1:0]  width_pan;
  logic [dsps_pkg::TILT_W-1:0] width_tilt;

  modport source (output valid, pwm_pan, pwm_tilt, width_pan, width_tilt, input ready);
  modport sink   (input valid, pwm_pan, pwm_tilt, width_pan, width_tilt, output ready);
endinterface

// ===== hw/rtl/dual_servo_pwm_stepper.sv =====
`timescale 1ns / 1ps

// Two-channel servo PWM generator with step and set commands.
// Commands arrive on cmd_ch_i (cmd, position) and each one produces exactly
// one result on res_ch_o (pwm_pan, pwm_tilt, width_pan, width_tilt).
// A transfer occurs on a clock edge with valid and ready both high.
// The command is captured in an input register, evaluated in one pass of
// combinational logic, and the result lands in an output register.
// Throughput is one command per cycle while the receiver keeps taking results;
// the state update and the result register are loaded in the same cycle.
// When the receiver stalls, the result holds and one more command waits in
// the input register; after that cmd_ch_i.ready drops until the result is
// taken.
// The step size register is written with step_size_we_i and step_size_i.
// Reset clears both registers, sets the period counter to zero, both
// levels low, pan position and width to 15, tilt position and width to 5,
// and the step size to 2.
module dual_servo_pwm_stepper #(
  parameter int unsigned PERIOD_TICKS = 200,
  parameter int unsigned PAN_MAX      = 25,
  parameter int unsigned TILT_MAX     = 10,
  parameter int unsigned WIDTH_MIN    = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_size_we_i,
  input  logic [dsps_pkg::STEP_W-1:0] step_size_i,
  dsps_cmd_if.sink                    cmd_ch_i,
  dsps_res_if.source                  res_ch_o
);

  dsps_pkg::stage_t stage;
  logic             take;

  dsps_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_ch_i),
    .take_i  (take),
    .stage_o (stage)
  );

  dsps_core #(
    .PERIOD_TICKS (PERIOD_TICKS),
    .PAN_MAX      (PAN_MAX),
    .TILT_MAX     (TILT_MAX),
    .WIDTH_MIN    (WIDTH_MIN)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_size_we_i (step_size_we_i),
    .step_size_i    (step_size_i),
    .stage_i        (stage),
    .take_o         (take),
    .res_o          (res_ch_o)
  );

endmodule

// ===== hw/rtl/dsps_in_reg.sv =====
`timescale 1ns / 1ps

module dsps_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  dsps_cmd_if.sink         cmd_i,
  input  logic             take_i,
  output dsps_pkg::stage_t stage_o
);

  logic               valid_q, valid_d;
  dsps_pkg::in_item_t item_q;

  assign cmd_i.ready = !valid_q || take_i;
  assign valid_d     = cmd_i.ready ? cmd_i.valid : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ready && cmd_i.valid) begin
      item_q.cmd      <= cmd_i.cmd;
      item_q.position <= cmd_i.position;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.item  = item_q;

endmodule

// ===== hw/rtl/dsps_core.sv =====
`timescale 1ns / 1ps

module dsps_core #(
  parameter int unsigned PERIOD_TICKS = 200,
  parameter int unsigned PAN_MAX      = 25,
  parameter int unsigned TILT_MAX     = 10,
  parameter int unsigned WIDTH_MIN    = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_size_we_i,
  input  logic [dsps_pkg::STEP_W-1:0] step_size_i,
  input  dsps_pkg::stage_t            stage_i,
  output logic                        take_o,
  dsps_res_if.source                  res_o
);

  localparam logic [7:0] PeriodLim = 8'(PERIOD_TICKS);
  localparam logic [7:0] PanMax8   = 8'(PAN_MAX);
  localparam logic [7:0] TiltMax8  = 8'(TILT_MAX);
  localparam logic [7:0] MinW8     = 8'(WIDTH_MIN);
  localparam logic [5:0] PanMax6   = 6'(PAN_MAX);
  localparam logic [5:0] TiltMax6  = 6'(TILT_MAX);
  localparam logic [5:0] MinW6     = 6'(WIDTH_MIN);

  function automatic logic [7:0] clamp_w(logic [7:0] v, logic [7:0] hi);
    logic [7:0] r;
    if (v <= MinW8) begin
      r = MinW8;
    end else if (v >= hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [dsps_pkg::STEP_W-1:0] step_q;
  logic [dsps_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic [dsps_pkg::PAN_W-1:0]  pan_pos_q, pan_pos_d, pan_width_q, pan_width_d;
  logic [dsps_pkg::TILT_W-1:0] tilt_pos_q, tilt_pos_d, tilt_width_q, tilt_width_d;
  logic                        pan_lvl_q, pan_lvl_d, tilt_lvl_q, tilt_lvl_d;
  logic                        res_valid_q, res_valid_d;
  logic                        fire;

  logic [5:0] step6, pan6, tilt6;
  logic [5:0] pan_sum, pan_diff, tilt_sum, tilt_diff;
  logic [dsps_pkg::PAN_W-1:0]  pan_up, pan_dn;
  logic [dsps_pkg::TILT_W-1:0] tilt_up, tilt_dn;
  logic [7:0] cnt_inc, pan_src, tilt_src, pan_clamp, tilt_clamp;
  logic [dsps_pkg::POS_W-1:0] position;

  assign fire   = stage_i.valid && (!res_valid_q || res_o.ready);
  assign take_o = fire;
  assign position = stage_i.item.position;

  assign step6     = 6'(step_q);
  assign pan6      = 6'(pan_pos_q);
  assign tilt6     = 6'(tilt_pos_q);
  assign pan_sum   = pan6 + step6;
  assign pan_diff  = pan6 - step6;
  assign tilt_sum  = tilt6 + step6;
  assign tilt_diff = tilt6 - step6;
  assign pan_up    = (pan_sum <= PanMax6) ? pan_sum[4:0] : PanMax6[4:0];
  assign pan_dn    = (MinW6 + step6 <= pan6) ? pan_diff[4:0] : MinW6[4:0];
  assign tilt_up   = (tilt_sum <= TiltMax6) ? tilt_sum[3:0] : TiltMax6[3:0];
  assign tilt_dn   = (MinW6 + step6 <= tilt6) ? tilt_diff[3:0] : MinW6[3:0];
  assign cnt_inc   = cnt_q + 8'd1;

  always_comb begin
    cnt_d      = cnt_q;
    pan_pos_d  = pan_pos_q;
    tilt_pos_d = tilt_pos_q;
    pan_lvl_d  = pan_lvl_q;
    tilt_lvl_d = tilt_lvl_q;
    unique case (stage_i.item.cmd)
      dsps_pkg::CMD_TICK: begin
        pan_lvl_d  = cnt_q <= 8'(pan_width_q);
        tilt_lvl_d = cnt_q <= 8'(tilt_width_q);
        cnt_d      = (cnt_inc >= PeriodLim) ? 8'd0 : cnt_inc;
      end
      dsps_pkg::CMD_PAN_UP:  pan_pos_d  = pan_up;
      dsps_pkg::CMD_PAN_DN:  pan_pos_d  = pan_dn;
      dsps_pkg::CMD_TILT_UP: tilt_pos_d = tilt_up;
      dsps_pkg::CMD_TILT_DN: tilt_pos_d = tilt_dn;
      default: ;
    endcase
  end

  assign pan_src    = (stage_i.item.cmd == dsps_pkg::CMD_SET_PAN) ? position : 8'(pan_pos_d);
  assign tilt_src   = (stage_i.item.cmd == dsps_pkg::CMD_SET_TILT) ? position : 8'(tilt_pos_d);
  assign pan_clamp  = clamp_w(pan_src, PanMax8);
  assign tilt_clamp = clamp_w(tilt_src, TiltMax8);

  always_comb begin
    pan_width_d  = pan_width_q;
    tilt_width_d = tilt_width_q;
    case (stage_i.item.cmd) inside
      dsps_pkg::CMD_PAN_UP, dsps_pkg::CMD_PAN_DN, dsps_pkg::CMD_SET_PAN:
        pan_width_d = pan_clamp[4:0];
      dsps_pkg::CMD_TILT_UP, dsps_pkg::CMD_TILT_DN, dsps_pkg::CMD_SET_TILT:
        tilt_width_d = tilt_clamp[3:0];
      default: ;
    endcase
  end

  assign res_valid_d = fire ? 1'b1 : (res_o.ready ? 1'b0 : res_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= dsps_pkg::STEP_RESET;
      cnt_q        <= '0;
      pan_pos_q    <= dsps_pkg::PAN_POS_RESET;
      tilt_pos_q   <= dsps_pkg::TILT_POS_RESET;
      pan_width_q  <= dsps_pkg::PAN_POS_RESET;
      tilt_width_q <= dsps_pkg::TILT_POS_RESET;
      pan_lvl_q    <= 1'b0;
      tilt_lvl_q   <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (step_size_we_i) begin
        step_q <= step_size_i;
      end
      if (fire) begin
        cnt_q        <= cnt_d;
        pan_pos_q    <= pan_pos_d;
        tilt_pos_q   <= tilt_pos_d;
        pan_width_q  <= pan_width_d;
        tilt_width_q <= tilt_width_d;
        pan_lvl_q    <= pan_lvl_d;
        tilt_lvl_q   <= tilt_lvl_d;
      end
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.pwm_pan    = pan_lvl_q;
  assign res_o.pwm_tilt   = tilt_lvl_q;
  assign res_o.width_pan  = pan_width_q;
  assign res_o.width_tilt = tilt_width_q;

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < PeriodLim) else $error("period counter out of range");

  a_no_take_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_o.ready |-> !fire) else $error("transfer taken while result stalled");

  a_cnt_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && stage_i.item.cmd != dsps_pkg::CMD_TICK |=> $stable(cnt_q))
    else $error("counter moved on a non-tick command");

  a_pan_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && stage_i.item.cmd == dsps_pkg::CMD_TICK |=>
      pan_lvl_q == ($past(cnt_q) <= 8'($past(pan_width_q))))
    else $error("pan level does not match compare");

  a_hold_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(pan_lvl_q) && $stable(tilt_lvl_q) && $stable(pan_width_q))
    else $error("state changed without a transfer");
`endif

endmodule
